// File: rtl/vtpdf_pkg.sv
// Package: constants, types and position helpers for the VLAN TCP port drop filter.
`default_nettype none
package vtpdf_pkg;

  localparam logic [15:0] TYPE_VLAN     = 16'h8100;
  localparam logic [15:0] TYPE_IPV4     = 16'h0800;
  localparam logic [7:0]  PROTO_TCP     = 8'd6;
  localparam logic [15:0] DROP_PORT_RST = 16'd443;

  localparam logic [7:0] POS_TYPE_HI  = 8'd12;
  localparam logic [7:0] POS_TYPE_LO  = 8'd13;
  localparam logic [7:0] POS_INNER_HI = 8'd16;
  localparam logic [7:0] POS_INNER_LO = 8'd17;
  localparam logic [7:0] IP_START_UNTAGGED = 8'd14;
  localparam logic [7:0] IP_START_TAGGED   = 8'd18;
  localparam logic [7:0] OFS_IP_PROTO  = 8'd9;
  localparam logic [7:0] OFS_TCP_DPORT = 8'd2;
  localparam logic [7:0] OFS_TCP_DOFF  = 8'd12;
  localparam logic [3:0] MIN_HDR_WORDS = 4'd5;
  localparam logic [7:0] POS_MAX       = 8'd255;
  localparam logic [8:0] MIN_FRAME_LEN = 9'd14;

  typedef struct packed {
    logic [7:0]  byte_pos;
    logic [15:0] outer_type;
    logic        is_vlan;
    logic [15:0] inner_type;
    logic [3:0]  ip_words;
    logic [7:0]  ip_proto;
    logic [15:0] tcp_dport;
    logic [3:0]  tcp_words;
  } frame_t;

  typedef struct packed {
    logic done;
    logic drop;
  } verdict_t;

  function automatic logic [7:0] words_to_bytes(input logic [3:0] words);
    return {2'b00, words, 2'b00};
  endfunction

endpackage
`default_nettype wire

// File: rtl/vtpdf_if.sv
// Interfaces: byte input channel and verdict output channel.
`default_nettype none
interface vtpdf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface vtpdf_out_if;
  logic valid;
  logic ready;
  logic drop;

  modport source (output valid, output drop, input ready);
  modport sink   (input valid, input drop, output ready);
endinterface
`default_nettype wire

// File: rtl/vtpdf_parser.sv
// Header parser: per-frame field capture and end-of-frame verdict.
`default_nettype none
module vtpdf_parser (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              beat_en,
  input  wire logic [7:0]        data_byte,
  input  wire logic              last_byte,
  input  wire logic [15:0]       drop_port,
  output vtpdf_pkg::verdict_t    verdict
);

  vtpdf_pkg::frame_t frame_r;
  vtpdf_pkg::frame_t frame_nxt;
  vtpdf_pkg::frame_t cap;

  logic [7:0] pos;
  logic [7:0] ip_start;
  logic [7:0] tcp_start;
  logic [7:0] cap_ip_start;
  logic [7:0] cap_tcp_start;
  logic [7:0] cap_tcp_end;
  logic [8:0] frame_len;
  logic       drop_ok;

  assign pos       = frame_r.byte_pos;
  assign ip_start  = frame_r.is_vlan ? vtpdf_pkg::IP_START_TAGGED
                                     : vtpdf_pkg::IP_START_UNTAGGED;
  assign tcp_start = ip_start + vtpdf_pkg::words_to_bytes(frame_r.ip_words);

  always_comb begin
    cap = frame_r;
    if (pos == vtpdf_pkg::POS_TYPE_HI) begin
      cap.outer_type[15:8] = data_byte;
    end else if (pos == vtpdf_pkg::POS_TYPE_LO) begin
      cap.outer_type[7:0] = data_byte;
      cap.is_vlan = ({frame_r.outer_type[15:8], data_byte} == vtpdf_pkg::TYPE_VLAN);
    end else if (frame_r.is_vlan && pos == vtpdf_pkg::POS_INNER_HI) begin
      cap.inner_type[15:8] = data_byte;
    end else if (frame_r.is_vlan && pos == vtpdf_pkg::POS_INNER_LO) begin
      cap.inner_type[7:0] = data_byte;
    end

    if (pos >= vtpdf_pkg::IP_START_UNTAGGED) begin
      if (pos == ip_start) begin
        cap.ip_words = data_byte[3:0];
      end else if (pos == ip_start + vtpdf_pkg::OFS_IP_PROTO) begin
        cap.ip_proto = data_byte;
      end
      if (frame_r.ip_words >= vtpdf_pkg::MIN_HDR_WORDS && pos > ip_start) begin
        if (pos == tcp_start + vtpdf_pkg::OFS_TCP_DPORT) begin
          cap.tcp_dport[15:8] = data_byte;
        end else if (pos == tcp_start + vtpdf_pkg::OFS_TCP_DPORT + 8'd1) begin
          cap.tcp_dport[7:0] = data_byte;
        end else if (pos == tcp_start + vtpdf_pkg::OFS_TCP_DOFF) begin
          cap.tcp_words = data_byte[7:4];
        end
      end
    end
  end

  // verdict on the captured fields, frame length includes this beat
  assign frame_len     = {1'b0, pos} + 9'd1;
  assign cap_ip_start  = (cap.outer_type == vtpdf_pkg::TYPE_VLAN)
                         ? vtpdf_pkg::IP_START_TAGGED : vtpdf_pkg::IP_START_UNTAGGED;
  assign cap_tcp_start = cap_ip_start + vtpdf_pkg::words_to_bytes(cap.ip_words);
  assign cap_tcp_end   = cap_tcp_start + vtpdf_pkg::words_to_bytes(cap.tcp_words);

  always_comb begin
    drop_ok = 1'b1;
    if (frame_len < vtpdf_pkg::MIN_FRAME_LEN) begin
      drop_ok = 1'b0;
    end else if (cap.outer_type == vtpdf_pkg::TYPE_VLAN) begin
      if (frame_len < {1'b0, vtpdf_pkg::IP_START_TAGGED} ||
          cap.inner_type != vtpdf_pkg::TYPE_IPV4) begin
        drop_ok = 1'b0;
      end
    end else if (cap.outer_type != vtpdf_pkg::TYPE_IPV4) begin
      drop_ok = 1'b0;
    end
    if (cap.ip_words < vtpdf_pkg::MIN_HDR_WORDS ||
        {1'b0, cap_tcp_start} > frame_len ||
        cap.ip_proto != vtpdf_pkg::PROTO_TCP ||
        cap.tcp_words < vtpdf_pkg::MIN_HDR_WORDS ||
        {1'b0, cap_tcp_end} > frame_len ||
        cap.tcp_dport != drop_port) begin
      drop_ok = 1'b0;
    end
  end

  assign verdict.done = beat_en && last_byte;
  assign verdict.drop = drop_ok;

  always_comb begin
    frame_nxt = frame_r;
    if (beat_en) begin
      if (last_byte) begin
        frame_nxt = '0;
      end else begin
        frame_nxt = cap;
        if (pos != vtpdf_pkg::POS_MAX) begin
          frame_nxt.byte_pos = pos + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r <= '0;
    end else begin
      frame_r <= frame_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/vlan_tcp_port_drop_filter.sv
// Top level: VLAN-aware IPv4 TCP destination port drop filter.
//
//   channel  dir  payload                  beat meaning
//   in_bus   in   data_byte[7:0] last_byte one frame byte, wire order
//   out_bus  out  drop                     one verdict per frame
//   cfg_*    in   cfg_wdata[15:0]          drop_port write
//
// One byte per cycle; the verdict is registered and shows the cycle after the last byte.
// in_bus.ready drops only while a verdict waits on a stalled out_bus.
// Synchronous active-low reset clears frame state; drop_port resets to 443.
`default_nettype none
module vlan_tcp_port_drop_filter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  vtpdf_in_if.sink         in_bus,
  vtpdf_out_if.source      out_bus,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  logic [15:0]         drop_port_r;
  logic                out_valid_r;
  logic                out_drop_r;
  logic                beat_en;
  vtpdf_pkg::verdict_t verdict;

  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign beat_en      = in_bus.valid && in_bus.ready;

  vtpdf_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat_en   (beat_en),
    .data_byte (in_bus.data_byte),
    .last_byte (in_bus.last_byte),
    .drop_port (drop_port_r),
    .verdict   (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_port_r <= vtpdf_pkg::DROP_PORT_RST;
    end else if (cfg_we) begin
      drop_port_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (verdict.done) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (verdict.done) begin
      out_drop_r <= verdict.drop;
    end
  end

  assign out_bus.valid = out_valid_r;
  assign out_bus.drop  = out_drop_r;

endmodule
`default_nettype wire

// File: rtl/vtpdf_checker.sv
// Port-level checker for the drop filter, bound to the top level.
`default_nettype none
module vtpdf_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic in_last,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_drop
);

  logic in_beat;
  assign in_beat = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drop))
    else $error("stalled verdict changed");

  a_last_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && in_last |=> out_valid)
    else $error("last beat produced no verdict");

  a_verdict_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (!$past(out_valid) || $past(out_ready)) |-> $past(in_beat && in_last))
    else $error("verdict without a last beat");

  a_stall_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while verdict stalled");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("verdict valid after reset");

endmodule

bind vlan_tcp_port_drop_filter vtpdf_checker u_vtpdf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_bus.valid),
  .in_ready  (in_bus.ready),
  .in_last   (in_bus.last_byte),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .out_drop  (out_bus.drop)
);
`default_nettype wire

// File: sim/testbench.sv
// Testbench for vlan_tcp_port_drop_filter: random and directed frames checked against a predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT   = 5000;
  localparam int STALL_LEN    = 300;
  localparam int DRAIN_CYCLES = 4;
  localparam int MAX_REPORTS  = 10;
  localparam logic [15:0] TYPE_IPV6 = 16'h86DD;
  localparam logic [7:0]  PROTO_UDP = 8'd17;
  localparam logic [15:0] T_IPV4    = vtpdf_pkg::TYPE_IPV4;
  localparam logic [15:0] T_VLAN    = vtpdf_pkg::TYPE_VLAN;
  localparam logic [7:0]  P_TCP     = vtpdf_pkg::PROTO_TCP;
  localparam logic [15:0] RST_PORT  = vtpdf_pkg::DROP_PORT_RST;

  typedef logic [7:0] frame_q_t[$];

  class verdict_scoreboard;
    logic [15:0] drop_port = vtpdf_pkg::DROP_PORT_RST;
    logic [7:0]  pos;
    logic [15:0] outer_type;
    logic [15:0] inner_type;
    logic        is_vlan;
    logic [3:0]  ip_words;
    logic [3:0]  tcp_words;
    logic [7:0]  ip_proto;
    logic [15:0] tcp_dport;
    bit          expected_drop[$];
    int          mismatches;
    int          frames;
    int          drops;
    int          checked;

    function new();
      clear_frame();
    endfunction

    function void clear_frame();
      pos        = '0;
      outer_type = '0;
      inner_type = '0;
      is_vlan    = 1'b0;
      ip_words   = '0;
      tcp_words  = '0;
      ip_proto   = '0;
      tcp_dport  = '0;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      int p;
      int ipst;
      int tst;
      int len;
      bit hit;
      p = int'(pos);
      ipst = is_vlan ? int'(vtpdf_pkg::IP_START_TAGGED) : int'(vtpdf_pkg::IP_START_UNTAGGED);
      if (p == vtpdf_pkg::POS_TYPE_HI) begin
        outer_type[15:8] = b;
      end else if (p == vtpdf_pkg::POS_TYPE_LO) begin
        outer_type[7:0] = b;
        is_vlan = (outer_type == vtpdf_pkg::TYPE_VLAN);
      end else if (is_vlan && p == vtpdf_pkg::POS_INNER_HI) begin
        inner_type[15:8] = b;
      end else if (is_vlan && p == vtpdf_pkg::POS_INNER_LO) begin
        inner_type[7:0] = b;
      end
      if (p >= vtpdf_pkg::IP_START_UNTAGGED) begin
        if (p == ipst) begin
          ip_words = b[3:0];
        end else if (p == ipst + vtpdf_pkg::OFS_IP_PROTO) begin
          ip_proto = b;
        end
        if (ip_words >= vtpdf_pkg::MIN_HDR_WORDS && p > ipst) begin
          tst = ipst + 4 * ip_words;
          if (p == tst + vtpdf_pkg::OFS_TCP_DPORT) begin
            tcp_dport[15:8] = b;
          end else if (p == tst + vtpdf_pkg::OFS_TCP_DPORT + 1) begin
            tcp_dport[7:0] = b;
          end else if (p == tst + vtpdf_pkg::OFS_TCP_DOFF) begin
            tcp_words = b[7:4];
          end
        end
      end
      if (last) begin
        len  = p + 1;
        ipst = is_vlan ? int'(vtpdf_pkg::IP_START_TAGGED)
                       : int'(vtpdf_pkg::IP_START_UNTAGGED);
        tst  = ipst + 4 * ip_words;
        hit  = len >= vtpdf_pkg::MIN_FRAME_LEN
            && (is_vlan ? (len >= vtpdf_pkg::IP_START_TAGGED
                           && inner_type == vtpdf_pkg::TYPE_IPV4)
                        : outer_type == vtpdf_pkg::TYPE_IPV4)
            && ip_words >= vtpdf_pkg::MIN_HDR_WORDS && tst <= len
            && ip_proto == vtpdf_pkg::PROTO_TCP
            && tcp_words >= vtpdf_pkg::MIN_HDR_WORDS && tst + 4 * tcp_words <= len
            && tcp_dport == drop_port;
        expected_drop.push_back(hit);
        frames++;
        drops += hit;
        clear_frame();
      end else if (pos != vtpdf_pkg::POS_MAX) begin
        pos++;
      end
    endfunction

    function void check_verdict(logic d);
      bit want;
      checked++;
      if (expected_drop.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("verdict %0d: none expected, got drop=%b", checked, d);
      end else begin
        want = expected_drop.pop_front();
        if (d !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("verdict %0d: expected drop=%b, got drop=%b", checked, want, d);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  bit          send_fast;
  bit          recv_fast;
  bit          pressure;
  int          stall_cycles;
  int          idle_cycles;
  int          bytes_sent;

  vtpdf_in_if  in_ch ();
  vtpdf_out_if out_ch ();

  verdict_scoreboard sb = new();

  vlan_tcp_port_drop_filter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_ch),
    .out_bus  (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_byte(in_ch.data_byte, in_ch.last_byte);
      if (out_ch.valid && out_ch.ready) sb.check_verdict(out_ch.drop);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // verdict receiver; a pending stall request holds ready low for a long stretch
  initial begin
    int n;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (stall_cycles > 0) begin
        n = stall_cycles;
        stall_cycles = 0;
      end else begin
        if ($urandom_range(0, 7) == 0) recv_fast = !recv_fast;
        n = recv_fast ? 0 : $urandom_range(0, 12);
      end
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  function automatic frame_q_t build_frame(logic [15:0] outer, logic [15:0] inner,
                                           logic [3:0] ihl, logic [7:0] proto,
                                           logic [15:0] port, logic [3:0] doff, int len);
    logic [7:0] raw [0:319];
    int ipst;
    int tst;
    frame_q_t q;
    foreach (raw[i]) raw[i] = 8'($urandom);
    raw[vtpdf_pkg::POS_TYPE_HI] = outer[15:8];
    raw[vtpdf_pkg::POS_TYPE_LO] = outer[7:0];
    if (outer == T_VLAN) begin
      raw[vtpdf_pkg::POS_INNER_HI] = inner[15:8];
      raw[vtpdf_pkg::POS_INNER_LO] = inner[7:0];
    end
    ipst = (outer == T_VLAN) ? int'(vtpdf_pkg::IP_START_TAGGED)
                             : int'(vtpdf_pkg::IP_START_UNTAGGED);
    raw[ipst][3:0] = ihl;
    raw[ipst + vtpdf_pkg::OFS_IP_PROTO] = proto;
    tst = ipst + 4 * ihl;
    raw[tst + vtpdf_pkg::OFS_TCP_DPORT]     = port[15:8];
    raw[tst + vtpdf_pkg::OFS_TCP_DPORT + 1] = port[7:0];
    raw[tst + vtpdf_pkg::OFS_TCP_DOFF][7:4] = doff;
    for (int i = 0; i < len && i < 320; i++) q.push_back(raw[i]);
    return q;
  endfunction

  task automatic send_frame(frame_q_t q);
    int gap;
    if ($urandom_range(0, 5) == 0) send_fast = !send_fast;
    foreach (q[i]) begin
      gap = (send_fast || pressure) ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_ch.valid     <= 1'b1;
      in_ch.data_byte <= q[i];
      in_ch.last_byte <= (i == q.size() - 1);
      do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
      bytes_sent++;
    end
  endtask

  // park the sender until every verdict is back, then let the block settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.expected_drop.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(int byte_goal, int frame_goal);
    logic [15:0] outer;
    logic [15:0] inner;
    logic [15:0] port;
    logic [3:0]  ihl;
    logic [3:0]  doff;
    logic [7:0]  proto;
    int k;
    int hdr;
    int len;
    int b0;
    int n_frames;
    b0 = bytes_sent;
    n_frames = 0;
    while (bytes_sent - b0 < byte_goal || n_frames < frame_goal) begin
      k = $urandom_range(0, 99);
      outer = k < 45 ? T_IPV4 : k < 85 ? T_VLAN : k < 93 ? TYPE_IPV6 : 16'($urandom);
      inner = ($urandom_range(0, 9) == 0) ? 16'($urandom) : T_IPV4;
      ihl   = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 4))
            : ($urandom_range(0, 9) < 7) ? 4'($urandom_range(5, 6))
            : 4'($urandom_range(5, 15));
      doff  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 4))
            : ($urandom_range(0, 9) < 7) ? 4'($urandom_range(5, 6))
            : 4'($urandom_range(5, 15));
      proto = ($urandom_range(0, 99) < 85) ? P_TCP : 8'($urandom);
      k = $urandom_range(0, 9);
      port = k < 5 ? sb.drop_port
           : k < 7 ? sb.drop_port ^ (16'd1 << $urandom_range(0, 15)) : 16'($urandom);
      hdr = ((outer == T_VLAN) ? int'(vtpdf_pkg::IP_START_TAGGED)
                               : int'(vtpdf_pkg::IP_START_UNTAGGED))
          + 4 * ihl + 4 * doff;
      k = $urandom_range(0, 99);
      len = k < 60 ? hdr + $urandom_range(0, 16)
          : k < 80 ? $urandom_range(1, hdr)
          : k < 96 ? $urandom_range(1, 20) : $urandom_range(200, 300);
      send_frame(build_frame(outer, inner, ihl, proto, port, doff, len));
      n_frames++;
    end
  endtask

  initial begin
    logic [15:0] port;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.last_byte <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed frames against the reset port
    send_frame(build_frame(T_IPV4, T_IPV4, 4'd5, P_TCP, RST_PORT, 4'd5, 1));
    send_frame(build_frame(T_IPV4, T_IPV4, 4'd5, P_TCP, RST_PORT, 4'd5, 13));
    send_frame(build_frame(T_IPV4, T_IPV4, 4'd5, P_TCP, RST_PORT, 4'd5, 54));
    send_frame(build_frame(T_IPV4, T_IPV4, 4'd5, P_TCP, 16'(RST_PORT + 1), 4'd5, 54));
    send_frame(build_frame(T_VLAN, T_IPV4, 4'd5, P_TCP, RST_PORT, 4'd5, 58));
    send_frame(build_frame(T_VLAN, TYPE_IPV6, 4'd5, P_TCP, RST_PORT, 4'd5, 58));
    send_frame(build_frame(T_VLAN, T_IPV4, 4'd5, P_TCP, RST_PORT, 4'd5, 17));
    send_frame(build_frame(TYPE_IPV6, T_IPV4, 4'd5, P_TCP, RST_PORT, 4'd5, 54));
    send_frame(build_frame(T_IPV4, T_IPV4, 4'd4, P_TCP, RST_PORT, 4'd5, 60));
    send_frame(build_frame(T_IPV4, T_IPV4, 4'd5, P_TCP, RST_PORT, 4'd4, 60));
    send_frame(build_frame(T_IPV4, T_IPV4, 4'd5, P_TCP, RST_PORT, 4'd5, 53));
    send_frame(build_frame(T_IPV4, T_IPV4, 4'd15, P_TCP, RST_PORT, 4'd15, 134));
    send_frame(build_frame(T_VLAN, T_IPV4, 4'd15, P_TCP, RST_PORT, 4'd15, 138));
    send_frame(build_frame(T_IPV4, T_IPV4, 4'd15, P_TCP, RST_PORT, 4'd5, 70));
    send_frame(build_frame(T_IPV4, T_IPV4, 4'd5, PROTO_UDP, RST_PORT, 4'd5, 54));
    send_frame(build_frame(T_IPV4, T_IPV4, 4'd5, P_TCP, RST_PORT, 4'd5, 300));

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      port = ph == 0 ? 16'h0000 : ph == 1 ? 16'hFFFF : ph == 4 ? RST_PORT : 16'($urandom);
      cfg_we    <= 1'b1;
      cfg_wdata <= port;
      @(posedge clk);
      cfg_we <= 1'b0;
      sb.drop_port = port;
      if (ph == 2) begin
        // receiver stalls long while the sender streams back to back
        pressure = 1'b1;
        stall_cycles = STALL_LEN;
      end
      run_phase(ph == 2 ? 100 : 50, ph == 2 ? 3 : 1);
      pressure = 1'b0;
    end

    drain();
    repeat (20) @(posedge clk);
    $display("%0d frames in %0d bytes, %0d dropped; tagged, untagged, short and malformed",
             sb.frames, bytes_sent, sb.drops);
    $display("frames over 7 port settings incl. 0 and 65535, with a long verdict stall; %0d bad",
             sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_drop.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
